[rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, control character codes and item types.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLS     = 80;
   localparam int ROWS     = 25;
   localparam int TAB_STOP = 8;
   localparam int CELLS    = COLS * ROWS;

   localparam int ADDR_W  = 11;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int BYTE_W  = 8;
   localparam int PHASE_W = $clog2(TAB_STOP);

   localparam logic [BYTE_W-1:0] RESET_ATTR   = 8'h07;
   localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [BYTE_W-1:0] CH_TAB       = 8'd9;
   localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [BYTE_W-1:0] CH_RETURN    = 8'd13;

   localparam logic ACT_PUT  = 1'b0;
   localparam logic ACT_READ = 1'b1;

   typedef struct packed {
      logic              action;
      logic [BYTE_W-1:0] char_code;
      logic [ADDR_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] cell_char;
      logic [BYTE_W-1:0] cell_attr;
      logic [COL_W-1:0]  cursor_col;
      logic [ROW_W-1:0]  cursor_row;
   } rsp_type;

endpackage

[rtl/tcw_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/text_console_writer.sv]
// ----------------------------------------------------------------------------
// Text console writer
// 80x25 text screen of character and attribute bytes with a cursor.
// ----------------------------------------------------------------------------
// Sequence: a read or a put that stays on screen is accepted, then gives its
//   result in ST_RESP; a put that runs past the bottom row first runs the
//   scroll copy, which moves one cell per cycle through the single write port
//   of each store RAM, with registered read data, and then gives its result.
// Items: no new item is taken until the last result is out; results cannot stall.
// Reset: cursor home, text_attr = 0x07, then a clearing pass writes every
//   cell to character 0, attribute 0x07 while busy stays high.
// ----------------------------------------------------------------------------
module text_console_writer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  tcw_pkg::req_type             req_item,
   output logic                         rsp_strobe,
   output tcw_pkg::rsp_type             rsp_item,
   input  logic                         csr_we,
   input  logic [tcw_pkg::BYTE_W-1:0]   csr_wdata
);

   localparam int AW  = tcw_pkg::ADDR_W;
   localparam int CW  = tcw_pkg::COL_W;
   localparam int RW  = tcw_pkg::ROW_W;
   localparam int BW  = tcw_pkg::BYTE_W;
   localparam int PW  = tcw_pkg::PHASE_W;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCROLL,
      ST_RESP
   } state_type;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   state_type       state_ff, state_in;
   logic [AW-1:0]   ptr_ff, ptr_in;          // clear / scroll sweep pointer
   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;
   logic [PW-1:0]   phase_ff, phase_in;      // column modulo tab stop
   logic [BW-1:0]   text_attr_ff, text_attr_in;
   logic            cell_ok_ff, cell_ok_in;  // result carries store data

   // ------------------------------------------------------------------
   // Store ports: character and attribute live in separate RAMs so that
   // backspace can zero the attribute without a read-modify-write.
   // ------------------------------------------------------------------
   logic            char_we, attr_we, rd_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic [BW-1:0]   char_wdata, attr_wdata;
   logic [BW-1:0]   char_rdata, attr_rdata;

   tcw_ram #(.WIDTH(BW), .DEPTH(tcw_pkg::CELLS)) u_char_ram (
      .clock   (clock),
      .wr_en   (char_we),
      .wr_addr (wr_addr),
      .wr_data (char_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (char_rdata)
   );

   tcw_ram #(.WIDTH(BW), .DEPTH(tcw_pkg::CELLS)) u_attr_ram (
      .clock   (clock),
      .wr_en   (attr_we),
      .wr_addr (wr_addr),
      .wr_data (attr_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (attr_rdata)
   );

   // ------------------------------------------------------------------
   // Cursor arithmetic for a put, all from the current cursor
   // ------------------------------------------------------------------
   logic            accept;
   logic [AW-1:0]   here;
   logic [CW:0]     tab_sum, inc_sum;
   logic [AW:0]     src_sum;
   logic [AW-1:0]   dst;

   assign accept  = start && !busy;
   assign here    = AW'(row_ff) * AW'(tcw_pkg::COLS) + AW'(col_ff);
   assign tab_sum = {1'b0, col_ff} + (CW+1)'(tcw_pkg::TAB_STOP) - (CW+1)'(phase_ff);
   assign inc_sum = {1'b0, col_ff} + (CW+1)'(1);

   // During scroll: read source ptr+COLS, write destination ptr-1 from the
   // registered read data.
   assign src_sum = {1'b0, ptr_ff} + (AW+1)'(tcw_pkg::COLS);
   assign dst     = ptr_ff - AW'(1);

   always_comb begin
      logic wrap_line;

      state_in     = state_ff;
      ptr_in       = ptr_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      phase_in     = phase_ff;
      cell_ok_in   = cell_ok_ff;
      text_attr_in = csr_we ? csr_wdata : text_attr_ff;
      wrap_line    = 1'b0;

      char_we      = 1'b0;
      attr_we      = 1'b0;
      wr_addr      = here;
      char_wdata   = req_item.char_code;
      attr_wdata   = text_attr_ff;
      rd_en        = 1'b0;
      rd_addr      = req_item.cell_index;

      case (state_ff)
         ST_CLEAR: begin
            // Blank every cell to the reset pattern
            char_we    = 1'b1;
            attr_we    = 1'b1;
            wr_addr    = ptr_ff;
            char_wdata = '0;
            attr_wdata = tcw_pkg::RESET_ATTR;
            if (ptr_ff == AW'(tcw_pkg::CELLS - 1)) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end

         ST_IDLE: begin
            if (accept) begin
               state_in   = ST_RESP;
               cell_ok_in = 1'b0;
               if (req_item.action == tcw_pkg::ACT_READ) begin
                  // Issue the read now; data shows in the result cycle
                  rd_en      = 1'b1;
                  cell_ok_in = req_item.cell_index < AW'(tcw_pkg::CELLS);
               end else begin
                  case (req_item.char_code)
                     tcw_pkg::CH_NEWLINE: begin
                        wrap_line = 1'b1;
                     end
                     tcw_pkg::CH_BACKSPACE: begin
                        if (col_ff != '0) begin
                           attr_we    = 1'b1;
                           attr_wdata = '0;
                           col_in     = col_ff - CW'(1);
                           phase_in   = (phase_ff == '0) ? PW'(tcw_pkg::TAB_STOP - 1)
                                                         : phase_ff - PW'(1);
                        end
                     end
                     tcw_pkg::CH_TAB: begin
                        if (tab_sum >= (CW+1)'(tcw_pkg::COLS)) begin
                           wrap_line = 1'b1;
                        end else begin
                           col_in   = tab_sum[CW-1:0];
                           phase_in = '0;
                        end
                     end
                     tcw_pkg::CH_RETURN: begin
                        col_in   = '0;
                        phase_in = '0;
                     end
                     default: begin
                        char_we = 1'b1;
                        attr_we = 1'b1;
                        if (inc_sum >= (CW+1)'(tcw_pkg::COLS)) begin
                           wrap_line = 1'b1;
                        end else begin
                           col_in   = inc_sum[CW-1:0];
                           phase_in = (phase_ff == PW'(tcw_pkg::TAB_STOP - 1)) ? '0
                                                                             : phase_ff + PW'(1);
                        end
                     end
                  endcase

                  // Advance to the next line; past the bottom, hold the last
                  // row and sweep the screen up by one row.
                  if (wrap_line) begin
                     col_in   = '0;
                     phase_in = '0;
                     if (row_ff == RW'(tcw_pkg::ROWS - 1)) begin
                        ptr_in   = '0;
                        state_in = ST_SCROLL;
                     end else begin
                        row_in = row_ff + RW'(1);
                     end
                  end
               end
            end
         end

         ST_SCROLL: begin
            if (src_sum < (AW+1)'(tcw_pkg::CELLS)) begin
               rd_en   = 1'b1;
               rd_addr = src_sum[AW-1:0];
            end
            if (ptr_ff != '0) begin
               char_we = 1'b1;
               attr_we = 1'b1;
               wr_addr = dst;
               if (dst < AW'(tcw_pkg::CELLS - tcw_pkg::COLS)) begin
                  char_wdata = char_rdata;
                  attr_wdata = attr_rdata;
               end else begin
                  // Bottom row: blank with the current attribute
                  char_wdata = '0;
                  attr_wdata = text_attr_ff;
               end
            end
            if (ptr_ff == AW'(tcw_pkg::CELLS)) begin
               ptr_in   = '0;
               state_in = ST_RESP;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end

         ST_RESP: begin
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         phase_ff     <= '0;
         cell_ok_ff   <= 1'b0;
         text_attr_ff <= tcw_pkg::RESET_ATTR;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         phase_ff     <= phase_in;
         cell_ok_ff   <= cell_ok_in;
         text_attr_ff <= text_attr_in;
      end
   end

   // ------------------------------------------------------------------
   // Handshake and result item
   // ------------------------------------------------------------------
   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_RESP);

   always_comb begin
      rsp_item.cell_char  = cell_ok_ff ? char_rdata : '0;
      rsp_item.cell_attr  = cell_ok_ff ? attr_rdata : '0;
      rsp_item.cursor_col = col_ff;
      rsp_item.cursor_row = row_ff;
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_cursor_on_screen : assert property (@(posedge clock) disable iff (reset)
      (col_ff < CW'(tcw_pkg::COLS)) && (row_ff < RW'(tcw_pkg::ROWS)))
      else $error("cursor left the screen");

   a_phase_tracks_col : assert property (@(posedge clock) disable iff (reset)
      phase_ff == PW'(col_ff % tcw_pkg::TAB_STOP))
      else $error("tab phase out of step with column");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted item did not raise busy");

   a_one_result : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held more than one cycle");

endmodule
